// ===== src/contiguous_page_allocator_defines.svh =====
// ----------------------------------------------------------------
// contiguous_page_allocator_defines: assertion macros
// same-cycle and next-cycle implication checks on clk, off during rst
// ----------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CPA_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CPA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cpa_pkg.sv =====
// ----------------------------------------------------------------
// cpa_pkg: shared types and constants
// field widths, opcodes, controller states, command and status bundles
// ----------------------------------------------------------------
`default_nettype none

package cpa_pkg;

  localparam int PAGES_DEF  = 4096;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam int OP_W     = 3;
  localparam int TAG_W    = 7;
  localparam int PCOUNT_W = 13;
  localparam int ADDR_W   = 24;
  localparam int ENTRY_W  = 8;
  localparam int CNT_W    = 25;
  localparam int CFG_W    = 12;
  localparam int HEAD_IDX = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 12'd256;
  localparam logic [CNT_W-1:0] COUNT_MAX = 25'h1FF_FFFF;

  localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK      = 3'd2;
  localparam logic [OP_W-1:0] OP_CNT_FREE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CNT_USED  = 3'd4;
  localparam logic [OP_W-1:0] OP_CNT_OWNER = 3'd5;

  typedef enum logic [2:0] {
    ST_CLR_INIT,
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } cpa_state_t;

  typedef struct packed {
    logic clear_init;
    logic clearing;
    logic load;
    logic scan;
    logic wr_step;
    logic result;
  } cpa_cmd_t;

  typedef struct packed {
    logic wr_done;
    logic scan_idle;
    logic found;
    logic stop;
  } cpa_stat_t;

endpackage

`default_nettype wire

// ===== src/cpa_req_if.sv =====
// ----------------------------------------------------------------
// cpa_req_if: request channel
// valid/ready handshake carrying one operation word
// ----------------------------------------------------------------
`default_nettype none

interface cpa_req_if;
  import cpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [TAG_W-1:0]    owner;
  logic                device_region;
  logic [PCOUNT_W-1:0] page_count;
  logic [ADDR_W-1:0]   start_address;
  logic [ADDR_W-1:0]   end_address;
  logic [ENTRY_W-1:0]  tag_value;

  modport source (
    output valid, opcode, owner, device_region, page_count,
           start_address, end_address, tag_value,
    input  ready
  );

  modport sink (
    input  valid, opcode, owner, device_region, page_count,
           start_address, end_address, tag_value,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/cpa_rsp_if.sv =====
// ----------------------------------------------------------------
// cpa_rsp_if: result channel
// valid/ready handshake carrying one result word
// ----------------------------------------------------------------
`default_nettype none

interface cpa_rsp_if;
  import cpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] base_address;
  logic              success;
  logic [CNT_W-1:0]  byte_count;

  modport source (
    output valid, base_address, success, byte_count,
    input  ready
  );

  modport sink (
    input  valid, base_address, success, byte_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/contiguous_page_allocator.sv =====
// ----------------------------------------------------------------
// contiguous_page_allocator: first-fit contiguous page-frame allocator
// one word at a time; scans read the page RAM one page a cycle, and count reads every page
// alloc: scan of the region, then fill of the run; free: chain scan clearing the run; mark: write sweep of the range
// rst: sync, clears every table entry with req.ready low; cfg writes always taken
// ----------------------------------------------------------------
`default_nettype none

`include "contiguous_page_allocator_defines.svh"

module contiguous_page_allocator #(
  parameter int PAGES = cpa_pkg::PAGES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  cpa_req_if.sink                         req,
  cpa_rsp_if.source                       rsp,
  input  wire logic                       cfg_write,
  input  wire logic [cpa_pkg::CFG_W-1:0]  cfg_data
);
  import cpa_pkg::*;

  // controller to datapath commands and status
  cpa_cmd_t  cmd;
  cpa_stat_t stat;

  // controller: clearing sweep after reset, then one request word at a time
  // through load, scan (alloc/free/count), write sweep (fill/mark) and finish;
  // finish waits only if the previous result word is still held in rsp
  cpa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .rsp_ready  (rsp.ready),
    .stat       (stat),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .cmd        (cmd)
  );

  // datapath: page table RAM (one read, one write per cycle), scan pointer
  // with registered read pipeline, run tracker for first fit, free chain
  // follower, page counter and the result word register
  cpa_datapath #(
    .PAGES (PAGES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .stat              (stat),
    .req_opcode        (req.opcode),
    .req_owner         (req.owner),
    .req_device_region (req.device_region),
    .req_page_count    (req.page_count),
    .req_start_address (req.start_address),
    .req_end_address   (req.end_address),
    .req_tag_value     (req.tag_value),
    .base_address      (rsp.base_address),
    .success           (rsp.success),
    .byte_count        (rsp.byte_count)
  );

  // no request taken while the table is being cleared
  `CPA_CHECK(a_no_req_in_clear, cmd.clearing, !req.ready, "request taken during clear")

  // one word in flight: after an accept the request side closes
  `CPA_CHECK_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second word taken")

  // a new result never overwrites a result word still waiting
  `CPA_CHECK(a_no_overwrite, cmd.result, !rsp.valid || rsp.ready, "result word overwritten")

  // a successful allocation carries no byte count
  `CPA_CHECK(a_alloc_no_count, rsp.valid && rsp.success, rsp.byte_count == '0, "count on alloc")

endmodule

`default_nettype wire

// ===== src/cpa_ram.sv =====
// ----------------------------------------------------------------
// cpa_ram: simple dual-port RAM
// one write port, one read port with registered read data
// ----------------------------------------------------------------
`default_nettype none

module cpa_ram #(
  parameter int WIDTH = cpa_pkg::ENTRY_W,
  parameter int DEPTH = cpa_pkg::PAGES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/cpa_ctrl.sv =====
// ----------------------------------------------------------------
// cpa_ctrl: sequencing state machine
// clearing pass, request load, table scan, write sweep, result hand-off
// ----------------------------------------------------------------
`default_nettype none

module cpa_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  input  wire logic [cpa_pkg::OP_W-1:0]  req_opcode,
  input  wire logic                      rsp_ready,
  input  wire cpa_pkg::cpa_stat_t        stat,
  output logic                           req_ready,
  output logic                           rsp_valid,
  output cpa_pkg::cpa_cmd_t              cmd
);
  import cpa_pkg::*;

  cpa_state_t state, state_next;
  logic       rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR_INIT;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_CLR_INIT: begin
        cmd.clear_init = 1'b1;
        state_next     = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd.clearing = 1'b1;
        cmd.wr_step  = 1'b1;
        if (stat.wr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          case (req_opcode)
            OP_ALLOC, OP_FREE, OP_CNT_FREE, OP_CNT_USED, OP_CNT_OWNER: begin
              state_next = ST_SCAN;
            end
            OP_MARK: begin
              state_next = ST_WRITE;
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.found) begin
          state_next = ST_WRITE;
        end else if (stat.stop || stat.scan_idle) begin
          state_next = ST_FINISH;
        end
      end
      ST_WRITE: begin
        cmd.wr_step = 1'b1;
        if (stat.wr_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.result = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLR_INIT;
      end
    endcase
  end

  always_comb begin
    if (cmd.result) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

`default_nettype wire

// ===== src/cpa_datapath.sv =====
// ----------------------------------------------------------------
// cpa_datapath: page table and scan datapath
// page RAM, scan pointer and bound, run tracker, counters, result word
// ----------------------------------------------------------------
`default_nettype none

module cpa_datapath #(
  parameter int PAGES = cpa_pkg::PAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [cpa_pkg::CFG_W-1:0]     cfg_data,
  input  wire cpa_pkg::cpa_cmd_t             cmd,
  output cpa_pkg::cpa_stat_t                 stat,
  input  wire logic [cpa_pkg::OP_W-1:0]      req_opcode,
  input  wire logic [cpa_pkg::TAG_W-1:0]     req_owner,
  input  wire logic                          req_device_region,
  input  wire logic [cpa_pkg::PCOUNT_W-1:0]  req_page_count,
  input  wire logic [cpa_pkg::ADDR_W-1:0]    req_start_address,
  input  wire logic [cpa_pkg::ADDR_W-1:0]    req_end_address,
  input  wire logic [cpa_pkg::ENTRY_W-1:0]   req_tag_value,
  output logic      [cpa_pkg::ADDR_W-1:0]    base_address,
  output logic                               success,
  output logic      [cpa_pkg::CNT_W-1:0]     byte_count
);
  import cpa_pkg::*;

  localparam int PW  = $clog2(PAGES);
  localparam int PCW = $clog2(PAGES + 1);

  logic [CFG_W-1:0]    cfg;
  logic [OP_W-1:0]     op;
  logic [TAG_W-1:0]    owner;
  logic [PCOUNT_W-1:0] count;
  logic [ENTRY_W-1:0]  tag;
  logic [TAG_W-1:0]    ftag;

  logic [PCW-1:0] ptr, lim, run, cnt;
  logic [PW-1:0]  ev_idx, first, first_eff;
  logic           ev_vld, head_ev, found_flag;

  logic               ev_on, pg_free, found, stop, free_clr, hit, issue;
  logic               ram_we, ram_re;
  logic [PW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, rdata;

  logic [31:0] bound_w, lo_w, hi_w, sp_w, ep_w, ld_ptr_w, ld_lim_w, base_w;
  logic [47:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      cfg <= cfg_data;
    end
  end

  // start and bound of the sweep for each operation
  always_comb begin
    bound_w  = (32'(cfg) > 32'(PAGES)) ? 32'(PAGES) : 32'(cfg);
    lo_w     = req_device_region ? 32'd0 : bound_w;
    hi_w     = req_device_region ? bound_w : 32'(PAGES);
    sp_w     = 32'(req_start_address) >> PAGE_SHIFT;
    ep_w     = 32'(req_end_address) >> PAGE_SHIFT;
    ld_ptr_w = 32'd0;
    ld_lim_w = 32'd0;
    case (req_opcode)
      OP_ALLOC: begin
        ld_ptr_w = lo_w;
        ld_lim_w = hi_w;
      end
      OP_FREE: begin
        ld_ptr_w = (sp_w > 32'(PAGES)) ? 32'(PAGES) : sp_w;
        ld_lim_w = 32'(PAGES);
      end
      OP_MARK: begin
        // start above end leaves ptr at or past lim
        ld_ptr_w = (sp_w > 32'(PAGES)) ? 32'(PAGES) : sp_w;
        ld_lim_w = (ep_w >= 32'(PAGES)) ? 32'(PAGES) : ep_w + 32'd1;
      end
      OP_CNT_FREE, OP_CNT_USED, OP_CNT_OWNER: begin
        ld_ptr_w = 32'd0;
        ld_lim_w = 32'(PAGES);
      end
      default: begin
        ld_ptr_w = 32'd0;
        ld_lim_w = 32'd0;
      end
    endcase
  end

  // evaluation of the entry read in the previous cycle
  always_comb begin
    ev_on     = cmd.scan && ev_vld;
    pg_free   = (rdata == '0);
    first_eff = (run == '0) ? ev_idx : first;
    found     = ev_on && (op == OP_ALLOC) && pg_free &&
                (32'(run) + 32'd1 >= 32'(count));
    stop      = ev_on && (op == OP_FREE) &&
                (head_ev ? !rdata[HEAD_IDX]
                         : (rdata[HEAD_IDX] || (rdata[TAG_W-1:0] != ftag)));
    free_clr  = ev_on && (op == OP_FREE) && (head_ev || !stop);
    case (op)
      OP_CNT_FREE:  hit = pg_free;
      OP_CNT_USED:  hit = !pg_free;
      OP_CNT_OWNER: hit = (rdata[TAG_W-1:0] == owner);
      default:      hit = 1'b0;
    endcase
    issue = (cmd.scan || cmd.wr_step) && (ptr < lim);
  end

  always_comb begin
    ram_re    = cmd.scan && (ptr < lim);
    ram_we    = (cmd.wr_step && (ptr < lim)) || free_clr;
    ram_waddr = free_clr ? ev_idx : ptr[PW-1:0];
    if (free_clr || cmd.clearing) begin
      ram_wdata = '0;
    end else if (op == OP_MARK) begin
      ram_wdata = tag;
    end else if (ptr[PW-1:0] == first) begin
      ram_wdata = {1'b1, owner};
    end else begin
      ram_wdata = {1'b0, owner};
    end
  end

  cpa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAGES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr[PW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    ev_vld <= ram_re;
    ev_idx <= ptr[PW-1:0];

    if (cmd.clear_init) begin
      ptr <= '0;
      lim <= PCW'(PAGES);
    end else if (cmd.load) begin
      ptr        <= ld_ptr_w[PCW-1:0];
      lim        <= ld_lim_w[PCW-1:0];
      op         <= req_opcode;
      owner      <= req_owner;
      count      <= (req_page_count == '0) ? PCOUNT_W'(1) : req_page_count;
      tag        <= req_tag_value;
      run        <= '0;
      cnt        <= '0;
      head_ev    <= 1'b1;
      found_flag <= 1'b0;
    end else if (found) begin
      // switch the pointer over to the fill sweep of the run
      ptr        <= PCW'(first_eff);
      lim        <= PCW'(ev_idx) + PCW'(1);
      first      <= first_eff;
      found_flag <= 1'b1;
    end else begin
      if (issue) begin
        ptr <= ptr + PCW'(1);
      end
      if (ev_on) begin
        head_ev <= 1'b0;
        if (head_ev) begin
          ftag <= rdata[TAG_W-1:0];
        end
        if (!pg_free) begin
          run <= '0;
        end else begin
          if (run == '0) begin
            first <= ev_idx;
          end
          run <= run + PCW'(1);
        end
        if (hit) begin
          cnt <= cnt + PCW'(1);
        end
      end
    end
  end

  always_comb begin
    base_w = 32'(first) << PAGE_SHIFT;
    prod   = 48'(cnt) << PAGE_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      base_address <= found_flag ? base_w[ADDR_W-1:0] : '0;
      success      <= found_flag;
      if ((op == OP_CNT_FREE) || (op == OP_CNT_USED) || (op == OP_CNT_OWNER)) begin
        byte_count <= (prod > 48'(COUNT_MAX)) ? COUNT_MAX : prod[CNT_W-1:0];
      end else begin
        byte_count <= '0;
      end
    end
  end

  always_comb begin
    stat.wr_done   = (ptr >= lim);
    stat.scan_idle = !ev_vld && (ptr >= lim);
    stat.found     = found;
    stat.stop      = stop;
  end

endmodule

`default_nettype wire
